/* rtl/ilsi_pkg.sv */
// Shared types and constants for the indexed list with shift insert.
// Used by ilsi_cell, ilsi_ctrl and the top level indexed_list_with_shift_insert.
`timescale 1ns / 1ps
`default_nettype none

package ilsi_pkg;

  // Capacity and element width of the list.
  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;

  // Derived widths: an entry index, the count (which can equal DEPTH),
  // the fixed request port widths, and a compare width covering both.
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } st_t;

  // What the cell row does at the next clock edge.
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } act_t;

  // Command broadcast to every cell.
  typedef struct packed {
    act_t                  act;
    logic [IDX_W-1:0]      idx;
    logic [ELEM_WIDTH-1:0] elem;
  } cell_ctl_t;

  // Response information from the controller to the output stage.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] count_next;
    st_t              status;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/indexed_list_with_shift_insert.sv */
// Indexed list with shift insert: a bounded ordered list of DEPTH elements
// held in a row of cells. A request word is taken at any clock edge where
// start is high; busy never rises, so one word can follow another in every
// cycle. Each request takes one cycle: its result appears on element_out,
// entry_count and status one cycle after acceptance, marked by done for a
// single cycle, and the receiver must take it then. Insert and remove move
// every affected cell to its neighbor at the same clock edge, so their cost
// does not depend on position or count. Failed requests leave the list as
// it was and return zero in element_out.
// Depends on ilsi_pkg, ilsi_cell and ilsi_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_with_shift_insert
  import ilsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        operation,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [WORD_W-1:0] element_in,
  output logic                   done,
  output logic [WORD_W-1:0]      element_out,
  output logic [POS_W-1:0]       entry_count,
  output logic [1:0]             status
);

  logic                  fire;
  cell_ctl_t             ctl;
  rsp_t                  rsp;
  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_word;

  // The cell row finishes every request at the edge that takes it, so the block never stalls.
  assign busy = 1'b0;
  assign fire = start && !busy;

  ilsi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .operation  (operation),
    .position   (position),
    .element_in (element_in),
    .ctl        (ctl),
    .rsp        (rsp)
  );

  // Row of cells; the ends see zero from outside the row.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] low_in;
    logic [ELEM_WIDTH-1:0] high_in;
    if (i == 0) begin : g_first
      assign low_in = '0;
    end else begin : g_mid_low
      assign low_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign high_in = '0;
    end else begin : g_mid_high
      assign high_in = cell_data[i+1];
    end
    ilsi_cell u_cell (
      .clk       (clk),
      .index     (IDX_W'(i)),
      .ctl       (ctl),
      .from_low  (low_in),
      .from_high (high_in),
      .data      (cell_data[i])
    );
  end

  // Read select: an AND-OR over the cells, one of which matches the index.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (IDX_W'(i) == rsp.rd_idx) begin
        rd_word = rd_word | cell_data[i];
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fire;
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (fire) begin
      element_out <= rsp.rd_en ? WORD_W'(rd_word) : '0;
      entry_count <= POS_W'(rsp.count_next);
      status      <= rsp.status;
    end
  end

  // Every accepted request yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst) fire |=> done)
    else $error("accepted request produced no result");

  // A failed request never returns an element.
  assert property (@(posedge clk) disable iff (rst)
      done && (status != ST_OK) |-> (element_out == '0))
    else $error("failed request returned an element");

  // An empty-list failure reports an empty list.
  assert property (@(posedge clk) disable iff (rst)
      done && (status == ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with nonzero count");

  // A full-list failure reports a full list.
  assert property (@(posedge clk) disable iff (rst)
      done && (status == ST_FULL) |-> (entry_count == POS_W'(DEPTH)))
    else $error("full status with count below capacity");

endmodule

`default_nettype wire

/* rtl/ilsi_cell.sv */
// One storage cell of the list: holds a single element and can load a new
// value, take its lower neighbor's value or take its upper neighbor's value.
// Depends on ilsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilsi_cell
  import ilsi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [IDX_W-1:0]      index,
  input  wire cell_ctl_t             ctl,
  input  wire logic [ELEM_WIDTH-1:0] from_low,
  input  wire logic [ELEM_WIDTH-1:0] from_high,
  output logic      [ELEM_WIDTH-1:0] data
);

  logic [ELEM_WIDTH-1:0] data_next;

  // Select the new content of this cell from the broadcast command.
  always_comb begin
    data_next = data;
    case (ctl.act)
      ACT_WRITE: begin
        if (index == ctl.idx) begin
          data_next = ctl.elem;
        end
      end
      ACT_INSERT: begin
        if (index == ctl.idx) begin
          data_next = ctl.elem;
        end else if (index > ctl.idx) begin
          data_next = from_low;
        end
      end
      ACT_REMOVE: begin
        if (index >= ctl.idx) begin
          data_next = from_high;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // The element itself needs no reset: it is read only after being written.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

/* rtl/ilsi_ctrl.sv */
// Request decoder and count register: checks each request against the count,
// forms the command for the cell row and the response information.
// Depends on ilsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilsi_ctrl
  import ilsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [2:0]        operation,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [WORD_W-1:0] element_in,
  output cell_ctl_t              ctl,
  output rsp_t                   rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] cnt_idx;
  logic [IDX_W-1:0] last_idx;
  logic             full;
  logic             empty;
  op_t              op;

  // Comparisons between the request index and the count.
  assign op       = op_t'(operation);
  assign pos_c    = CMP_W'(position);
  assign cnt_c    = CMP_W'(count);
  assign pos_idx  = IDX_W'(pos_c);
  assign cnt_idx  = IDX_W'(count);
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  // Decode the request into a cell command, a read select and a status.
  always_comb begin
    ctl.act        = ACT_NONE;
    ctl.idx        = pos_idx;
    ctl.elem       = ELEM_WIDTH'(element_in);
    rsp.rd_en      = 1'b0;
    rsp.rd_idx     = pos_idx;
    rsp.status     = ST_OK;
    count_next     = count;
    case (op)
      OP_PUSH: begin
        if (full) begin
          rsp.status = ST_FULL;
        end else begin
          ctl.act    = ACT_WRITE;
          ctl.idx    = cnt_idx;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.rd_en  = 1'b1;
          rsp.rd_idx = last_idx;
          count_next = count - CNT_W'(1);
        end
      end
      OP_GET, OP_SET, OP_REMOVE: begin
        if (empty) begin
          rsp.status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          rsp.status = ST_RANGE;
        end else if (op == OP_GET) begin
          rsp.rd_en = 1'b1;
        end else if (op == OP_SET) begin
          ctl.act = ACT_WRITE;
        end else begin
          ctl.act    = ACT_REMOVE;
          count_next = count - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          rsp.status = ST_FULL;
        end else if (pos_c > cnt_c) begin
          rsp.status = ST_RANGE;
        end else begin
          ctl.act    = ACT_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    // Nothing moves in the cell row unless a word is taken.
    if (!fire) begin
      ctl.act = ACT_NONE;
    end
    rsp.count_next = count_next;
  end

  // Live element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

/* tb/indexed_list_with_shift_insert_test.sv */
// Self-checking testbench for indexed_list_with_shift_insert: a directed table,
// then fill, drain and mixed request runs, checked against a shadow list or, for typed table rows, their own answers.
// Depends on ilsi_pkg and the block's RTL only.
`timescale 1ns / 1ps

module indexed_list_with_shift_insert_test;
  import ilsi_pkg::*;

  // One result word as the block reports it.
  typedef struct packed {
    logic [WORD_W-1:0] elem;
    logic [POS_W-1:0]  cnt;
    st_t               st;
  } list_result_t;

  // One row of the directed table. Rows with typed set carry their own answer.
  typedef struct {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] elem;
    bit                typed;
    logic [WORD_W-1:0] want_elem;
    logic [POS_W-1:0]  want_cnt;
    st_t               want_st;
  } plan_row_t;

  typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIX} run_kind_t;

  localparam int PLAN_ROWS       = 25;
  localparam int WORDS_PER_PHASE = 150;
  localparam int MAX_GAP         = 30;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [2:0]        operation = OP_NOP;
  logic [POS_W-1:0]  position = '0;
  logic [WORD_W-1:0] element_in = '0;
  logic              busy;
  logic              done;
  logic [WORD_W-1:0] element_out;
  logic [POS_W-1:0]  entry_count;
  logic [1:0]        status;

  // Shadow copy of the list and its fill level.
  logic [ELEM_WIDTH-1:0] shadow_list [DEPTH];
  int unsigned           shadow_count = 0;

  list_result_t expected_results [$];
  int           mismatches = 0;
  int           accepted_words = 0;
  int           status_seen [4] = '{0, 0, 0, 0};
  int unsigned  peak_fill = 0;
  int           sender_idle_pct = 0;
  run_kind_t    run_kind = RUN_MIX;
  int           run_left = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{OP_POP,    7'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, ST_EMPTY},
    '{OP_GET,    7'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, ST_EMPTY},
    '{OP_SET,    7'd64, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, 7'd0, ST_EMPTY},
    '{OP_REMOVE, 7'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, ST_EMPTY},
    '{OP_INSERT, 7'd1,  32'h0000_0001, 1'b1, 32'h0000_0000, 7'd0, ST_RANGE},
    '{OP_NOP,    7'd64, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_CLEAR,  7'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_PUSH,   7'd0,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 7'd1, ST_OK},
    '{OP_PUSH,   7'd64, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd2, ST_OK},
    '{OP_GET,    7'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 7'd2, ST_OK},
    '{OP_GET,    7'd2,  32'h0000_0000, 1'b1, 32'h0000_0000, 7'd2, ST_RANGE},
    '{OP_GET,    7'd64, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd2, ST_RANGE},
    '{OP_SET,    7'd2,  32'h1111_1111, 1'b1, 32'h0000_0000, 7'd2, ST_RANGE},
    '{OP_INSERT, 7'd3,  32'h2222_2222, 1'b1, 32'h0000_0000, 7'd2, ST_RANGE},
    '{OP_INSERT, 7'd0,  32'h1234_5678, 1'b0, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_INSERT, 7'd3,  32'hA5A5_A5A5, 1'b0, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_SET,    7'd1,  32'h5A5A_5A5A, 1'b0, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_REMOVE, 7'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_GET,    7'd1,  32'h0000_0000, 1'b0, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_REMOVE, 7'd2,  32'h0000_0000, 1'b0, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_POP,    7'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_NOP,    7'd0,  32'hFFFF_0000, 1'b0, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_CLEAR,  7'd5,  32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, ST_OK},
    '{OP_POP,    7'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, ST_EMPTY},
    '{OP_PUSH,   7'd0,  32'h8000_0001, 1'b1, 32'h0000_0000, 7'd1, ST_OK}
  };

  indexed_list_with_shift_insert dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .position    (position),
    .element_in  (element_in),
    .done        (done),
    .element_out (element_out),
    .entry_count (entry_count),
    .status      (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return the word it must produce.
  function automatic list_result_t apply_list_request(op_t op, logic [POS_W-1:0] pos,
                                                      logic [WORD_W-1:0] val);
    list_result_t r;
    int unsigned  i;
    r = '0;
    r.st = ST_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          shadow_list[shadow_count] = val[ELEM_WIDTH-1:0];
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          shadow_count--;
          r.elem = WORD_W'(shadow_list[shadow_count]);
        end
      end
      OP_GET, OP_SET, OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.st = ST_EMPTY;
        end else if (pos >= shadow_count) begin
          r.st = ST_RANGE;
        end else if (op == OP_GET) begin
          r.elem = WORD_W'(shadow_list[pos]);
        end else if (op == OP_SET) begin
          shadow_list[pos] = val[ELEM_WIDTH-1:0];
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_count--;
        end
      end
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.st = ST_FULL;
        end else if (pos > shadow_count) begin
          r.st = ST_RANGE;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[pos] = val[ELEM_WIDTH-1:0];
          shadow_count++;
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.cnt = POS_W'(shadow_count);
    return r;
  endfunction

  // Present one request word and hold it until the block takes it.
  task automatic issue_request(op_t op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val,
                               bit typed, list_result_t want);
    list_result_t got;
    operation  <= op;
    position   <= pos;
    element_in <= val;
    start      <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    got = apply_list_request(op, pos, val);
    expected_results.push_back(typed ? want : got);
    accepted_words++;
    status_seen[got.st]++;
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endtask

  // Random pause on the request side, at the current pacing.
  task automatic idle_sender();
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result word has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic op_t any_operation();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return OP_NOP;
    if (roll < 4) return OP_CLEAR;
    return op_t'($urandom_range(0, 5));
  endfunction

  // Mostly legal positions for the current fill, sometimes anywhere from 0 to DEPTH.
  function automatic logic [POS_W-1:0] choose_position(op_t op);
    int hi;
    hi = -1;
    if (op == OP_INSERT) begin
      hi = shadow_count;
    end else if ((op == OP_GET || op == OP_SET || op == OP_REMOVE) && shadow_count > 0) begin
      hi = shadow_count - 1;
    end
    if (hi >= 0 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, hi));
    return POS_W'($urandom_range(0, 64));
  endfunction

  function automatic logic [WORD_W-1:0] choose_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return $urandom;
  endfunction

  // Random requests in runs: fill to full and past it, drain to empty and
  // past it, or a free mix of every operation.
  task automatic choose_random_request(output op_t op, output logic [POS_W-1:0] pos,
                                       output logic [WORD_W-1:0] val);
    int roll;
    if (run_left <= 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        run_kind = RUN_FILL;
        run_left = DEPTH - shadow_count + 8;
      end else if (roll < 65) begin
        run_kind = RUN_DRAIN;
        run_left = shadow_count + 6;
      end else begin
        run_kind = RUN_MIX;
        run_left = $urandom_range(20, 60);
      end
    end
    run_left--;
    roll = $urandom_range(0, 99);
    case (run_kind)
      RUN_FILL:  op = (roll < 50) ? OP_PUSH : (roll < 95) ? OP_INSERT : any_operation();
      RUN_DRAIN: op = (roll < 50) ? OP_POP : (roll < 95) ? OP_REMOVE : any_operation();
      default:   op = any_operation();
    endcase
    pos = choose_position(op);
    val = choose_value();
  endtask

  // Result words are sampled mid-cycle, away from the edge where new
  // expectations are queued.
  always @(negedge clk) begin
    list_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected: element_out %h count %0d status %0d",
                 $time, element_out, entry_count, status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (element_out !== want.elem) begin
          $display("%0t: element_out expected %h, got %h", $time, want.elem, element_out);
          mismatches++;
        end
        if (entry_count !== want.cnt) begin
          $display("%0t: entry_count expected %0d, got %0d", $time, want.cnt, entry_count);
          mismatches++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d, got %0d", $time, want.st, status);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then four pacing phases of random runs.
  initial begin
    int                row;
    int                phase;
    int                phase_words;
    int                pacing [4];
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] val;
    list_result_t      want;
    // No idling, sender idle 52%, no idling again, sender idle 27%.
    pacing = '{0, 52, 0, 27};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < PLAN_ROWS; row++) begin
      want.elem = plan[row].want_elem;
      want.cnt  = plan[row].want_cnt;
      want.st   = plan[row].want_st;
      issue_request(plan[row].op, plan[row].pos, plan[row].elem, plan[row].typed, want);
    end
    wait_for_results();

    want = '0;
    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct = pacing[phase];
      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) begin
        idle_sender();
        choose_random_request(op, pos, val);
        issue_request(op, pos, val, 1'b0, want);
        if (op != OP_NOP) phase_words++;
      end
      wait_for_results();
    end
    repeat (4) @(posedge clk);

    $display("Sent %0d request words over four pacing phases, peak fill %0d of %0d.",
             accepted_words, peak_fill, DEPTH);
    $display("Status mix: ok %0d, out of range %0d, empty %0d, full %0d.",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_EMPTY],
             status_seen[ST_FULL]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d result words outstanding.", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
